// File: sv/nssf_pkg.sv
// Shared types, register indexes and arithmetic constants of the slew filter.
package nssf_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 24;
    localparam int TERM_W     = 48;
    localparam int INV_W      = 20;
    localparam int ALPHA_W    = 19;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Internal widths
    localparam int DIFF_W  = SAMPLE_W + 1;   // sample difference
    localparam int SLEW_W  = 45;             // |slew| < 2^44
    localparam int MUL_A_W = SLEW_W + 1;     // multiplier operand A, signed
    localparam int MUL_B_W = GAIN_W + 1;     // multiplier operand B, signed
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 64;             // every product fits here
    localparam int FRAC_W  = 18;             // alpha fraction bits
    localparam int GFRAC_W = 16;             // gain fraction bits
    localparam int HI_W    = 53;             // |f|[44:16] * gain
    localparam int SUM_W   = HI_W + 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << FRAC_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FAST    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MAG     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THIRD   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FAST     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MAG      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE      = CFG_IDX_W'(7);

    // Filter lane indexes
    localparam logic [1:0] FLT_FAST  = 2'd0;
    localparam logic [1:0] FLT_MAG   = 2'd1;
    localparam logic [1:0] FLT_THIRD = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] grad_sample;
        logic                       first_of_wave;
    } in_item_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] term_fast;
        logic signed [TERM_W-1:0] term_mag;
        logic signed [TERM_W-1:0] term_third;
    } out_item_t;

endpackage

// File: sv/nerve_stim_slew_filter_core.sv
// Slew-rate nerve stimulation filter for one gradient axis, shared-multiplier core.
// Words are processed one at a time; a new input is taken only in the idle state.
// All ten products (slew, three filter updates, two partial products per scaled
//   term) go through one 46x25 multiplier.
// A finished word waits in the output register; the next input is taken meanwhile.
// Reset (aresetn low, synchronous): abs_mode = 1; other config registers, history, m_valid zero.
module nerve_stim_slew_filter_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  nssf_pkg::in_item_t                   s_data,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output nssf_pkg::out_item_t                  m_data,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nssf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nssf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import nssf_pkg::*;

    // Sequencer: slew product, three filter updates (multiply then
    // accumulate), three scaled terms (high product, low product, sum).
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SLEW = 8'b0000_0010,
        ST_FMUL = 8'b0000_0100,
        ST_FACC = 8'b0000_1000,
        ST_THI  = 8'b0001_0000,
        ST_TLO  = 8'b0010_0000,
        ST_TSUM = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    // Configuration registers
    logic [INV_W-1:0]   inv_step_rate_reg;
    logic [ALPHA_W-1:0] alpha_fast_reg, alpha_mag_reg, alpha_third_reg;
    logic [GAIN_W-1:0]  gain_fast_reg, gain_mag_reg, gain_third_reg;
    logic               abs_mode_reg;

    // Per-axis state and working registers
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SLEW_W-1:0]   filt_reg [3];
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [SLEW_W-1:0]   slew_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [HI_W-1:0]            hi_reg;
    logic signed [TERM_W-1:0]   term_reg [3];
    out_item_t                  out_reg;
    logic                       out_valid_reg;

    logic in_fire;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // ---------------------------------------------------------------
    // Per-lane selection
    // ---------------------------------------------------------------
    logic [ALPHA_W-1:0]       alpha_raw, alpha_sel;
    logic [GAIN_W-1:0]        gain_sel;
    logic signed [SLEW_W-1:0] filt_cur;
    logic [SLEW_W-1:0]        slew_abs, filt_abs;
    logic signed [MUL_A_W-1:0] x_sel, x_minus_f;

    always_comb begin
        case (idx_reg)
            FLT_FAST: begin
                alpha_raw = alpha_fast_reg;
                gain_sel  = gain_fast_reg;
            end
            FLT_MAG: begin
                alpha_raw = alpha_mag_reg;
                gain_sel  = gain_mag_reg;
            end
            default: begin
                alpha_raw = alpha_third_reg;
                gain_sel  = gain_third_reg;
            end
        endcase
    end

    // alpha above one acts as one
    assign alpha_sel = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
    assign filt_cur  = filt_reg[idx_reg];
    assign slew_abs  = slew_reg[SLEW_W-1] ? SLEW_W'(-slew_reg) : SLEW_W'(slew_reg);
    assign filt_abs  = filt_cur[SLEW_W-1] ? SLEW_W'(-filt_cur) : SLEW_W'(filt_cur);
    assign x_sel     = (idx_reg == FLT_MAG) ? $signed({1'b0, slew_abs})
                                            : MUL_A_W'(slew_reg);
    assign x_minus_f = x_sel - MUL_A_W'(filt_cur);

    // ---------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_SLEW: begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = $signed(MUL_B_W'(inv_step_rate_reg));
            end
            ST_FMUL: begin
                mul_a = x_minus_f;
                mul_b = $signed(MUL_B_W'(alpha_sel));
            end
            ST_THI: begin
                mul_a = $signed(MUL_A_W'(filt_abs[SLEW_W-1:GFRAC_W]));
                mul_b = $signed(MUL_B_W'(gain_sel));
            end
            ST_TLO: begin
                mul_a = $signed(MUL_A_W'(filt_abs[GFRAC_W-1:0]));
                mul_b = $signed(MUL_B_W'(gain_sel));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Filter update: f + floor((alpha*(x - f) + half) / 2^18)
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [SLEW_W-1:0] filt_new;
    assign prod_rnd = (prod_reg + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
    assign filt_new = filt_cur + SLEW_W'(prod_rnd);

    // Term: round the low partial product, add, saturate, apply sign
    logic [GFRAC_W+GAIN_W:0]  lo_rnd;
    logic [SUM_W-1:0]         mag_sum;
    logic [TERM_W-2:0]        mag_sat;
    logic                     term_neg;
    logic signed [TERM_W-1:0] term_new;

    assign lo_rnd  = prod_reg[GFRAC_W+GAIN_W-1:0] + (GFRAC_W+GAIN_W+1)'(1 << (GFRAC_W - 1));
    assign mag_sum = SUM_W'(hi_reg) + SUM_W'(lo_rnd[GFRAC_W+GAIN_W:GFRAC_W]);
    assign mag_sat = (|mag_sum[SUM_W-1:TERM_W-1]) ? '1 : mag_sum[TERM_W-2:0];
    // outside abs mode, term two follows the slew sign, the others their filter's sign
    assign term_neg = !abs_mode_reg &&
                      ((idx_reg == FLT_MAG) ? slew_reg[SLEW_W-1] : filt_cur[SLEW_W-1]);
    assign term_new = term_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW: begin
                idx_next   = FLT_FAST;
                state_next = ST_FMUL;
            end
            ST_FMUL: state_next = ST_FACC;
            ST_FACC: begin
                if (idx_reg == FLT_THIRD) begin
                    idx_next   = FLT_FAST;
                    state_next = ST_THI;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_FMUL;
                end
            end
            ST_THI: state_next = ST_TLO;
            ST_TLO: state_next = ST_TSUM;
            ST_TSUM: begin
                if (idx_reg == FLT_THIRD) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_THI;
                end
            end
            ST_OUT: begin
                // output register free or emptying this cycle
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= FLT_FAST;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_step_rate_reg <= '0;
            alpha_fast_reg    <= '0;
            alpha_mag_reg     <= '0;
            alpha_third_reg   <= '0;
            gain_fast_reg     <= '0;
            gain_mag_reg      <= '0;
            gain_third_reg    <= '0;
            abs_mode_reg      <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_INV_STEP_RATE: inv_step_rate_reg <= cfg_data[INV_W-1:0];
                REG_ALPHA_FAST:    alpha_fast_reg    <= cfg_data[ALPHA_W-1:0];
                REG_ALPHA_MAG:     alpha_mag_reg     <= cfg_data[ALPHA_W-1:0];
                REG_ALPHA_THIRD:   alpha_third_reg   <= cfg_data[ALPHA_W-1:0];
                REG_GAIN_FAST:     gain_fast_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_MAG:      gain_mag_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_THIRD:    gain_third_reg    <= cfg_data[GAIN_W-1:0];
                REG_ABS_MODE:      abs_mode_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Axis state: previous sample and filter states
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                filt_reg[i] <= '0;
            end
        end else if (in_fire) begin
            prev_reg <= s_data.grad_sample;
            // new waveform: filters restart from zero
            if (s_data.first_of_wave) begin
                for (int i = 0; i < 3; i++) begin
                    filt_reg[i] <= '0;
                end
            end
        end else if (state_reg == ST_FACC) begin
            filt_reg[idx_reg] <= filt_new;
        end
    end

    // ---------------------------------------------------------------
    // Datapath working registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            diff_reg <= DIFF_W'(s_data.grad_sample) -
                        (s_data.first_of_wave ? DIFF_W'(0) : DIFF_W'(prev_reg));
        end
        case (state_reg)
            ST_SLEW: slew_reg <= mul_p[SLEW_W-1:0];
            ST_FMUL: prod_reg <= mul_p[PROD_W-1:0];
            ST_THI:  prod_reg <= mul_p[PROD_W-1:0];
            ST_TLO: begin
                hi_reg   <= prod_reg[HI_W-1:0];
                prod_reg <= mul_p[PROD_W-1:0];
            end
            ST_TSUM: term_reg[idx_reg] <= term_new;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.term_fast  <= term_reg[FLT_FAST];
            out_reg.term_mag   <= term_reg[FLT_MAG];
            out_reg.term_third <= term_reg[FLT_THIRD];
        end
    end

endmodule
